>>> rtl/mlrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrq_pkg
// Types, constants and helpers shared by the multilevel ready queue modules.
// ----------------------------------------------------------------------------
package mlrq_pkg;

  localparam int LEVELS   = 16;
  localparam int CAPACITY = 64;
  localparam int ID_BITS  = 8;

  localparam int LVL_W = $clog2(LEVELS);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_BOOST = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] process_id;
    logic [3:0] level;
    logic       is_idle;
  } in_t;

  typedef struct packed {
    logic [7:0] out_process_id;
    logic       idle_given;
    logic       status;
    logic [6:0] level_count;
    logic [6:0] total_count;
  } out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_BOOST
  } cell_op_t;

  typedef struct packed {
    logic               valid;
    logic [ID_BITS-1:0] id;
    logic [LVL_W-1:0]   lvl;
  } slot_t;

  typedef struct packed {
    cell_op_t           op;
    logic [ID_BITS-1:0] id;
    logic [LVL_W-1:0]   lvl;
  } cell_ctl_t;

  typedef struct packed {
    logic             inc;
    logic [LVL_W-1:0] inc_lvl;
    logic             dec;
    logic [LVL_W-1:0] dec_lvl;
    logic             boost;
    logic [CNT_W-1:0] total;
  } cnt_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Levels beyond the last one fold onto the least urgent level.
  function automatic logic [LVL_W-1:0] sat_level(input logic [3:0] lvl);
    if (int'(lvl) >= LEVELS) begin
      return LVL_W'(LEVELS - 1);
    end
    return LVL_W'(lvl);
  endfunction

endpackage
`default_nettype wire

>>> rtl/mlrq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrq_cell
// One slot of the ordered store; takes the new entry or a neighbor's entry.
// ----------------------------------------------------------------------------
module mlrq_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mlrq_pkg::cell_ctl_t  ctl,
  input  mlrq_pkg::slot_t      left_slot,
  input  wire                  left_after,
  input  mlrq_pkg::slot_t      right_slot,
  output mlrq_pkg::slot_t      slot,
  output logic                 after
);
  import mlrq_pkg::*;

  slot_t slot_r;
  slot_t slot_nxt;

  // This slot lies behind the insertion point of the new entry.
  assign after = !slot_r.valid || (slot_r.lvl > ctl.lvl);
  assign slot  = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (after && !left_after) begin
          slot_nxt.valid = 1'b1;
          slot_nxt.id    = ctl.id;
          slot_nxt.lvl   = ctl.lvl;
        end else if (after) begin
          slot_nxt = left_slot;
        end
      end
      CELL_POP:   slot_nxt = right_slot;
      CELL_BOOST: slot_nxt.lvl = '0;
      default:    slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mlrq_level_counts.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrq_level_counts
// Per-level entry counters, kept in step with the cell chain.
// ----------------------------------------------------------------------------
module mlrq_level_counts (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  mlrq_pkg::cnt_ctl_t           ctl,
  input  wire  [3:0]                   query_lvl,
  output logic [mlrq_pkg::CNT_W-1:0]   query_cnt
);
  import mlrq_pkg::*;

  logic [CNT_W-1:0] cnt_r   [LEVELS];
  logic [CNT_W-1:0] cnt_nxt [LEVELS];

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      if (ctl.boost) begin
        cnt_nxt[i] = (i == 0) ? ctl.total : '0;
      end else begin
        cnt_nxt[i] = cnt_r[i];
        if (ctl.inc && (ctl.inc_lvl == LVL_W'(i))) begin
          cnt_nxt[i] = cnt_r[i] + CNT_W'(1);
        end
        if (ctl.dec && (ctl.dec_lvl == LVL_W'(i))) begin
          cnt_nxt[i] = cnt_r[i] - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (en) begin
      for (int i = 0; i < LEVELS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // A level past the last one has no entries.
  always_comb begin
    if (int'(query_lvl) >= LEVELS) begin
      query_cnt = '0;
    end else begin
      query_cnt = cnt_r[LVL_W'(query_lvl)];
    end
  end

endmodule
`default_nettype wire

>>> rtl/multilevel_ready_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_ready_queue
// Scheduler ready queue with LEVELS FIFO levels held in a chain of cells.
// ----------------------------------------------------------------------------
//
//   channel   ports                      direction   handshake
//   input     start, busy, in_item       in          start high, busy low
//   result    out_valid, out_item        out         one-cycle strobe
//
// An item is taken at the edge where start is high and busy is low. Busy then
// stays high while the cell chain and the level counters apply the item in
// the execute state; the result is registered at the end of the execute cycle
// and shows on out_item for exactly one cycle with out_valid high. The next
// item may be taken in the same cycle in which the previous result is shown.
// Reset (rst_n low, synchronous) empties the store and the level counts.
// The receiver cannot stall, so no result is ever held back.
//
// The store is a row of CAPACITY cells kept in order: valid entries are packed
// from cell 0 upward, sorted by level and, within a level, by arrival. Each
// cell compares its own level with that of a new entry, so the insertion
// point falls out of neighbor comparisons and every cell behind it takes its
// left neighbor's entry in the same cycle. A dequeue takes cell 0 and every
// cell takes its right neighbor's entry. A boost clears the level of every
// entry, which leaves the order intact. Per-level counters, updated alongside
// the chain, answer size queries without a scan of the cells.
// ----------------------------------------------------------------------------
module multilevel_ready_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  mlrq_pkg::in_t     in_item,
  output logic              out_valid,
  output mlrq_pkg::out_t    out_item
);
  import mlrq_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  in_t              req_r;
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] total_nxt;
  out_t             out_r;
  out_t             out_nxt;
  logic             out_valid_r;
  logic             exec;

  cell_ctl_t        cell_ctl;
  cnt_ctl_t         cnt_ctl;
  slot_t            cell_q     [CAPACITY];
  logic             cell_after [CAPACITY];
  logic [CNT_W-1:0] query_cnt;

  logic             enq_ok;
  logic             enq_full;
  logic             deq_ok;
  logic             deq_empty;

  // Next-state logic: start moves idle to execute; execute always returns to idle.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    case (state_r)
      ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The item is held for the execute cycle.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_item;
    end
  end

  // Decode of the held item against the current fill. An idle process is
  // dropped before the fill check, so it never reports a full store.
  always_comb begin
    enq_ok    = (req_r.command == CMD_ENQ) && !req_r.is_idle
                && (total_r != CNT_W'(CAPACITY));
    enq_full  = (req_r.command == CMD_ENQ) && !req_r.is_idle
                && (total_r == CNT_W'(CAPACITY));
    deq_ok    = (req_r.command == CMD_DEQ) && (total_r != '0);
    deq_empty = (req_r.command == CMD_DEQ) && (total_r == '0);
  end

  always_comb begin
    cell_ctl.id  = ID_BITS'(req_r.process_id);
    cell_ctl.lvl = sat_level(req_r.level);
    cell_ctl.op  = CELL_HOLD;
    if (exec) begin
      if (enq_ok) begin
        cell_ctl.op = CELL_INSERT;
      end else if (deq_ok) begin
        cell_ctl.op = CELL_POP;
      end else if (req_r.command == CMD_BOOST) begin
        cell_ctl.op = CELL_BOOST;
      end
    end
  end

  always_comb begin
    total_nxt = total_r;
    if (enq_ok) begin
      total_nxt = total_r + CNT_W'(1);
    end else if (deq_ok) begin
      total_nxt = total_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (exec) begin
      total_r <= total_nxt;
    end
  end

  // The chain of cells. Cell 0 sees no entry in front of it, and the last
  // cell pulls in an empty slot on a dequeue.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    slot_t left_slot;
    logic  left_after;
    slot_t right_slot;

    if (g == 0) begin : g_first
      assign left_slot  = '0;
      assign left_after = 1'b0;
    end else begin : g_inner_left
      assign left_slot  = cell_q[g-1];
      assign left_after = cell_after[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_slot = '0;
    end else begin : g_inner_right
      assign right_slot = cell_q[g+1];
    end

    mlrq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .left_slot  (left_slot),
      .left_after (left_after),
      .right_slot (right_slot),
      .slot       (cell_q[g]),
      .after      (cell_after[g])
    );
  end

  // Level counters follow the same events as the chain.
  always_comb begin
    cnt_ctl.inc     = enq_ok;
    cnt_ctl.inc_lvl = sat_level(req_r.level);
    cnt_ctl.dec     = deq_ok;
    cnt_ctl.dec_lvl = cell_q[0].lvl;
    cnt_ctl.boost   = (req_r.command == CMD_BOOST);
    cnt_ctl.total   = total_r;
  end

  mlrq_level_counts u_counts (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (exec),
    .ctl       (cnt_ctl),
    .query_lvl (req_r.level),
    .query_cnt (query_cnt)
  );

  // Result of the item, registered at the end of the execute cycle.
  always_comb begin
    out_nxt                = '0;
    out_nxt.out_process_id = deq_ok ? 8'(cell_q[0].id) : 8'd0;
    out_nxt.idle_given     = deq_empty;
    out_nxt.status         = enq_full;
    out_nxt.level_count    = (req_r.command == CMD_QUERY) ? 7'(query_cnt) : 7'd0;
    out_nxt.total_count    = 7'(total_nxt);
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // An execute cycle is always followed by a cycle with busy low.
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // Every execute cycle is followed by a result strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("no result after an execute cycle");

  // The fill count never passes the store size.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(CAPACITY))
    else $error("entry total exceeds capacity");

  // An empty dequeue carries no id and no reject status.
  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.idle_given) |->
      (out_item.out_process_id == 8'd0) && !out_item.status)
    else $error("idle result carries an id or a reject");

endmodule
`default_nettype wire
